### rtl/core/tlsrd_pkg.sv
// Types and constants shared by the record deframer modules.
package tlsrd_pkg;

  localparam logic [7:0]  HDR_TYPE_BYTE = 8'h17;
  localparam logic [7:0]  HDR_VER_BYTE  = 8'h03;
  localparam logic [15:0] MAX_LEN_RESET = 16'd16384;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_HDR  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_ZERO_LEN = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    PH_TYPE    = 6'b000001,
    PH_VER1    = 6'b000010,
    PH_VER2    = 6'b000100,
    PH_LEN_HI  = 6'b001000,
    PH_LEN_LO  = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    status_t    status;
  } result_t;

endpackage

### rtl/core/tlsrd_parser.sv
// Header check, length capture and payload count for one byte per cycle while advance is high.
module tlsrd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       stream_byte,
  input  logic [15:0]      max_record_len,
  output tlsrd_pkg::result_t result,
  output logic             failed
);
  import tlsrd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic        failed_next;
  logic [15:0] len;
  logic [15:0] rem_dec;

  assign len     = {length_high, stream_byte};
  assign rem_dec = bytes_remaining - 16'd1;

  always_comb begin
    phase_next           = phase;
    length_high_next     = length_high;
    bytes_remaining_next = bytes_remaining;
    failed_next          = failed;
    result.valid         = 1'b0;
    result.data          = 8'd0;
    result.last          = 1'b0;
    result.status        = ST_OK;
    if (!failed) begin
      unique case (phase)
        PH_VER1, PH_VER2: begin
          if (stream_byte != HDR_VER_BYTE) begin
            result.valid  = 1'b1;
            result.status = ST_BAD_HDR;
          end else begin
            phase_next = (phase == PH_VER1) ? PH_VER2 : PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          length_high_next = stream_byte;
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len > max_record_len) begin
            result.valid  = 1'b1;
            result.status = ST_TOO_LONG;
          end else if (len == 16'd0) begin
            result.valid  = 1'b1;
            result.status = ST_ZERO_LEN;
          end else begin
            bytes_remaining_next = len;
            phase_next           = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          bytes_remaining_next = rem_dec;
          result.valid         = 1'b1;
          result.data          = stream_byte;
          if (rem_dec == 16'd0) begin
            result.last = 1'b1;
            phase_next  = PH_TYPE;
          end
        end
        default: begin
          // unused codes fall back to the first header byte
          if (stream_byte != HDR_TYPE_BYTE) begin
            result.valid  = 1'b1;
            result.status = ST_BAD_HDR;
          end else begin
            phase_next = PH_VER1;
          end
        end
      endcase
      if (result.valid && result.status != ST_OK) begin
        failed_next          = 1'b1;
        phase_next           = PH_TYPE;
        bytes_remaining_next = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_TYPE;
      length_high     <= 8'd0;
      bytes_remaining <= 16'd0;
      failed          <= 1'b0;
    end else if (advance) begin
      phase           <= phase_next;
      length_high     <= length_high_next;
      bytes_remaining <= bytes_remaining_next;
      failed          <= failed_next;
    end
  end

endmodule

### rtl/core/tls_record_deframer_core.sv
// Top level of the TLS application-data record deframer.
//
// Usage: bytes of the received stream enter on s_axis, one per transfer.
// Each record is a five-byte header (17 03 03, then a big-endian 16-bit
// length) and that many payload bytes. Header bytes give no output; each
// payload byte leaves on m_axis with tlast set on the last byte of its
// record and tuser holding status 0. The first bad header byte, a zero
// length or a length above max_record_len gives one result with data 0
// and a nonzero status, after which every input byte is dropped until reset.
// cfg_wr_en/cfg_wr_data set max_record_len; write it only while idle.
// An input transfer loads the input register; the parsed result, if any, then
// loads the result register, which drives m_axis_tvalid. Throughput: one byte
// per cycle while the receiver does not stall, set by the combinational parse
// step between the two registers.
// Reset (synchronous, rst high) clears both valid bits, the parser state
// and sets max_record_len to 16384. When the receiver stalls, the result
// register holds, the input register fills, and s_axis_tready drops.
module tls_record_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
  output logic        m_axis_tlast,   // record_end
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import tlsrd_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic [15:0] max_record_len;
  logic        out_free;
  logic        move;
  logic        out_load;
  logic        failed;
  result_t     res;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign move          = in_valid && out_free;
  assign out_load      = move && res.valid;
  assign s_axis_tready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_record_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_record_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  tlsrd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .advance        (move),
    .stream_byte    (in_byte),
    .max_record_len (max_record_len),
    .result         (res),
    .failed         (failed)
  );

  // hold the result until the receiver takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res.data;
      m_axis_tlast <= res.last;
      m_axis_tuser <= res.status;
    end
  end

`ifndef SYNTHESIS
  a_no_result_after_fail: assert property (@(posedge clk) disable iff (rst)
    failed |-> !res.valid)
    else $error("result produced after failure");

  a_error_result_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == 8'd0 && !m_axis_tlast))
    else $error("error result carries data or tlast");

  a_load_shows_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");

  a_ready_when_moving: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a downstream stall");
`endif

endmodule

### bench/tb_tls_record_deframer_core.sv
// Self-checking bench for the record deframer: records, limit changes, one closing fault.
`timescale 1ns / 100ps

module tb_tls_record_deframer_core;
  import tlsrd_pkg::*;

  localparam int ITEM_GOAL      = 1750;
  localparam int MAX_GAP        = 18;
  localparam int WATCHDOG_LIMIT = 600;
  localparam int SETTLE_CYCLES  = 4;

  typedef enum int {
    END_BAD_TYPE,
    END_BAD_VER1,
    END_BAD_VER2,
    END_TOO_LONG,
    END_ZERO_LEN
  } fault_kind_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    status_t    status;
  } deframed_t;

  // Tracks the parser state and holds the payload bytes and status still due.
  class record_scoreboard;
    deframed_t   due_q[$];
    logic [15:0] max_len;
    phase_t      ph;
    logic [7:0]  len_hi;
    logic [15:0] remaining;
    bit          failed;
    int          errors;
    int          checked;

    function new();
      max_len   = MAX_LEN_RESET;
      ph        = PH_TYPE;
      len_hi    = '0;
      remaining = '0;
      failed    = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void raise_fault(status_t st);
      deframed_t r;
      r.data    = '0;
      r.last    = 1'b0;
      r.status  = st;
      failed    = 1'b1;
      ph        = PH_TYPE;
      remaining = '0;
      due_q.push_back(r);
    endfunction

    function void parse_stream_byte(logic [7:0] b);
      deframed_t   r;
      logic [15:0] len;
      if (failed) return;
      case (ph)
        PH_VER1: begin
          if (b != HDR_VER_BYTE) raise_fault(ST_BAD_HDR);
          else ph = PH_VER2;
        end
        PH_VER2: begin
          if (b != HDR_VER_BYTE) raise_fault(ST_BAD_HDR);
          else ph = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hi = b;
          ph     = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len = {len_hi, b};
          if (len > max_len) raise_fault(ST_TOO_LONG);
          else if (len == 16'd0) raise_fault(ST_ZERO_LEN);
          else begin
            remaining = len;
            ph        = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          remaining = remaining - 16'd1;
          r.data    = b;
          r.last    = (remaining == 16'd0);
          r.status  = ST_OK;
          due_q.push_back(r);
          if (remaining == 16'd0) ph = PH_TYPE;
        end
        default: begin
          if (b != HDR_TYPE_BYTE) raise_fault(ST_BAD_HDR);
          else ph = PH_VER1;
        end
      endcase
    endfunction

    function void match_output(logic [7:0] data, logic last, status_t status);
      deframed_t e;
      if (due_q.size() == 0) begin
        $error("unexpected result: payload_byte %0h record_end %0b status %0d",
               data, last, status);
        errors++;
        return;
      end
      e = due_q.pop_front();
      checked++;
      if (data !== e.data) begin
        $error("payload_byte mismatch: expected %0h, actual %0h", e.data, data);
        errors++;
      end
      if (last !== e.last) begin
        $error("record_end mismatch: expected %0b, actual %0b", e.last, last);
        errors++;
      end
      if (status !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, status);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  record_scoreboard sb = new();

  bit          src_idle_on;
  bit          sink_idle_on;
  int          sink_stall;
  int          bytes_sent;
  int          records_sent;
  int          limit_writes;
  int          idle_cycles;
  fault_kind_t fault;

  tls_record_deframer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Note every transfer on both sides at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.parse_stream_byte(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.match_output(m_axis_tdata, m_axis_tlast, status_t'(m_axis_tuser));
      sink_stall = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    sink_stall    = 0;
    forever begin
      @(negedge clk);
      if (sink_stall > 0) begin
        m_axis_tready <= 1'b0;
        sink_stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tls_record_deframer_core regression: fail");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic [15:0] len);
    send_byte(HDR_TYPE_BYTE);
    send_byte(HDR_VER_BYTE);
    send_byte(HDR_VER_BYTE);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic send_record(input int len);
    send_header(16'(len));
    repeat (len) send_byte(8'($urandom_range(0, 255)));
    records_sent++;
  endtask

  // Hold off until every result is out and the pipeline has emptied.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    sb.max_len   = v;
    limit_writes++;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] x);
    return x ^ 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [15:0] pick_limit(input int idx);
    if (idx == 0) return 16'd1;
    if (idx == 1) return 16'hFFFF;
    case ($urandom_range(0, 3))
      0:       return MAX_LEN_RESET;
      1:       return 16'($urandom_range(1, 30));
      2:       return 16'($urandom_range(256, 400));
      default: return 16'($urandom_range(31, 65534));
    endcase
  endfunction

  initial begin
    int          idx;
    int          phase_goal;
    int          cap;
    int          len;
    logic [15:0] lim;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    src_idle_on   = 1'b0;
    sink_idle_on  = 1'b0;
    bytes_sent    = 0;
    records_sent  = 0;
    limit_writes  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: shortest records, payload extremes and header look-alikes.
    send_header(16'd1);
    send_byte(8'h00);
    send_header(16'd2);
    send_byte(8'hFF);
    send_byte(HDR_TYPE_BYTE);
    send_header(16'd3);
    send_byte(HDR_VER_BYTE);
    send_byte(HDR_TYPE_BYTE);
    send_byte(8'h80);
    records_sent += 3;
    settle();
    write_max_len(16'd1);
    send_header(16'd1);
    send_byte(8'h7F);
    records_sent++;
    settle();

    idx = 0;
    while (bytes_sent < ITEM_GOAL) begin
      lim = pick_limit(idx);
      write_max_len(lim);
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      cap = (lim > 300) ? 300 : int'(lim);
      // Start with a record of exactly the limit when it is short enough.
      if (cap == int'(lim)) send_record(cap);
      phase_goal = bytes_sent + $urandom_range(100, 250);
      while (bytes_sent < phase_goal && bytes_sent < ITEM_GOAL) begin
        if ($urandom_range(0, 9) == 0)
          len = (cap >= 256) ? $urandom_range(256, cap) : cap;
        else
          len = $urandom_range(1, (cap < 16) ? cap : 16);
        send_record(len);
      end
      settle();
      idx++;
    end

    // Close the run with one fault; everything after it is dropped.
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    fault = fault_kind_t'($urandom_range(0, 4));
    case (fault)
      END_BAD_TYPE: send_byte(other_than(HDR_TYPE_BYTE));
      END_BAD_VER1: begin
        send_byte(HDR_TYPE_BYTE);
        send_byte(other_than(HDR_VER_BYTE));
      end
      END_BAD_VER2: begin
        send_byte(HDR_TYPE_BYTE);
        send_byte(HDR_VER_BYTE);
        send_byte(other_than(HDR_VER_BYTE));
      end
      END_TOO_LONG: begin
        lim = 16'($urandom_range(1, 65534));
        write_max_len(lim);
        send_header(16'($urandom_range(int'(lim) + 1, 65535)));
      end
      default: send_header(16'd0);
    endcase
    repeat (20) send_byte(8'($urandom_range(0, 255)));
    send_record(4);
    settle();
    repeat (8) @(negedge clk);

    $display("Sent %0d bytes in %0d records across %0d limit writes; %0d results checked.",
             bytes_sent, records_sent, limit_writes, sb.checked);
    $display("Closing fault %s, followed by bytes that must be dropped.", fault.name());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tls_record_deframer_core regression: pass");
    end else begin
      $display("tls_record_deframer_core regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/tlsrd_pkg.sv
rtl/core/tlsrd_parser.sv
rtl/core/tls_record_deframer_core.sv
bench/tb_tls_record_deframer_core.sv
